// ----- sv/ccpd_pkg.sv -----
// ----------------------------------------------------------------------------
// ccpd_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the COBS
// packet decoder.
// ----------------------------------------------------------------------------
package ccpd_pkg;

    localparam int PAYLOAD_MAX = 1024;
    localparam int DCNT_W      = $clog2(PAYLOAD_MAX) + 1;

    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam int IDX_W       = 10;
    localparam int HDR_W       = 24;

    localparam logic [3:0] PH_CODE = 4'd0;
    localparam logic [3:0] PH_HDR1 = 4'd1;
    localparam logic [3:0] PH_HDR2 = 4'd2;
    localparam logic [3:0] PH_HDR3 = 4'd3;
    localparam logic [3:0] PH_ID   = 4'd4;
    localparam logic [3:0] PH_OFF1 = 4'd5;
    localparam logic [3:0] PH_OFF2 = 4'd6;
    localparam logic [3:0] PH_DATA = 4'd7;
    localparam logic [3:0] PH_CRC1 = 4'd8;
    localparam logic [3:0] PH_CRC2 = 4'd9;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_ID      = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [7:0]  COBS_MAX_CODE = 8'hFF;

    typedef struct packed {
        logic       clear;
        logic       dropped;
        logic [7:0] data;
    } t_token;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/cobs_crc_packet_decoder.sv -----
// ----------------------------------------------------------------------------
// cobs_crc_packet_decoder
// COBS deframer with header parsing and CRC-16/CCITT-FALSE check; reports
// id and payload bytes with their index, one result per received byte.
// ----------------------------------------------------------------------------
// An accepted byte is held in the token queue, then in the output register.
// Throughput: one byte per cycle unless o_stall; a 2-entry token queue sits
//   between the COBS front end and the parser so each side stalls on its own.
// Reset: synchronous, active low; clears frame state and the queue, sets
//   offsets_enabled to 1.
module cobs_crc_packet_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_frame_status,
    output logic [1:0]  o_byte_kind,
    output logic [9:0]  o_byte_index,
    output logic [7:0]  o_byte_value,
    output logic [9:0]  o_payload_length,
    output logic [3:0]  o_message_type,
    output logic        o_internal_flag,
    output logic        o_offset_flag,
    output logic [3:0]  o_id_length,
    output logic        o_response_flag,
    output logic [2:0]  o_ack_number,
    output logic [15:0] o_offset_value
);
    import ccpd_pkg::*;

    logic             r_offsets_enabled;
    logic             in_accept;
    t_token           front_token;
    t_token           q_token;
    t_qstat           q_stat;
    logic             tok_pop;
    logic [HDR_W-1:0] header;

    assign o_stall   = q_stat.full;
    assign in_accept = i_valid && !q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offsets_enabled <= 1'b1;
        end else if (i_cfg_we) begin
            r_offsets_enabled <= i_cfg_wdata;
        end
    end

    ccpd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .o_token   (front_token)
    );

    ccpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (in_accept),
        .i_wdata (front_token),
        .i_rd    (tok_pop),
        .o_rdata (q_token),
        .o_stat  (q_stat)
    );

    ccpd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_offsets_enabled (r_offsets_enabled),
        .i_tok_valid       (!q_stat.empty),
        .i_token           (q_token),
        .o_tok_pop         (tok_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_status    (o_frame_status),
        .o_byte_kind       (o_byte_kind),
        .o_byte_index      (o_byte_index),
        .o_byte_value      (o_byte_value),
        .o_header          (header),
        .o_offset          (o_offset_value)
    );

    assign o_payload_length = header[9:0];
    assign o_message_type   = header[13:10];
    assign o_internal_flag  = header[14];
    assign o_offset_flag    = header[15];
    assign o_id_length      = header[19:16];
    assign o_response_flag  = header[20];
    assign o_ack_number     = header[23:21];

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_status == ST_IDLE || o_frame_status == ST_OK ||
                     o_frame_status == ST_ERR))
        else $error("frame status out of range");

    a_no_byte_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_kind == KIND_NONE) |-> (o_byte_index == '0 && o_byte_value == '0))
        else $error("index or value set without a reported byte");

    a_ok_without_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_status == ST_OK) |-> (o_byte_kind == KIND_NONE))
        else $error("good frame reported together with a data byte");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && q_stat.empty && !o_valid) |=> ##1 o_valid)
        else $error("result missing two cycles after an accepted transaction");

endmodule

// ----- sv/ccpd_front.sv -----
// ----------------------------------------------------------------------------
// ccpd_front
// COBS unstuffing front end: classifies each received byte as frame clear,
// dropped code byte or decoded data byte.
// ----------------------------------------------------------------------------
module ccpd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output ccpd_pkg::t_token o_token
);
    import ccpd_pkg::*;

    logic [7:0] r_countdown, n_countdown;
    logic [7:0] r_last_code, n_last_code;
    t_token     token;

    always_comb begin
        n_countdown   = r_countdown;
        n_last_code   = r_last_code;
        token.clear   = 1'b0;
        token.dropped = 1'b0;
        token.data    = i_rx_byte;
        if (i_rx_byte == 8'h00) begin
            token.clear = 1'b1;
            n_countdown = 8'h00;
            n_last_code = 8'h00;
        end else if (r_countdown > 8'd1) begin
            n_countdown = r_countdown - 8'd1;
        end else begin
            n_countdown = i_rx_byte;
            n_last_code = i_rx_byte;
            if (r_last_code < COBS_MAX_CODE) begin
                token.data = 8'h00;
            end else begin
                token.dropped = 1'b1;
            end
        end
    end

    assign o_token = token;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= 8'h00;
            r_last_code <= 8'h00;
        end else if (i_accept) begin
            r_countdown <= n_countdown;
            r_last_code <= n_last_code;
        end
    end

endmodule

// ----- sv/ccpd_queue.sv -----
// ----------------------------------------------------------------------------
// ccpd_queue
// Short token queue between the COBS front end and the parser.
// ----------------------------------------------------------------------------
module ccpd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  ccpd_pkg::t_token i_wdata,
    input  logic             i_rd,
    output ccpd_pkg::t_token o_rdata,
    output ccpd_pkg::t_qstat o_stat
);
    import ccpd_pkg::*;

    t_token              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic                wr_en;
    logic                rd_en;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign wr_en        = i_wr && !o_stat.full;
    assign rd_en        = i_rd && !o_stat.empty;
    assign o_rdata      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/ccpd_back.sv -----
// ----------------------------------------------------------------------------
// ccpd_back
// Packet parser: header, id, offset, payload and CRC check, with the result
// output register.
// ----------------------------------------------------------------------------
module ccpd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_offsets_enabled,
    input  logic                   i_tok_valid,
    input  ccpd_pkg::t_token       i_token,
    output logic                   o_tok_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_frame_status,
    output logic [1:0]             o_byte_kind,
    output logic [9:0]             o_byte_index,
    output logic [7:0]             o_byte_value,
    output logic [ccpd_pkg::HDR_W-1:0] o_header,
    output logic [15:0]            o_offset
);
    import ccpd_pkg::*;

    logic [3:0]        r_phase,      n_phase;
    logic [4:0]        r_id_count,   n_id_count;
    logic [DCNT_W-1:0] r_data_count, n_data_count;
    logic [15:0]       r_crc,        n_crc;
    logic [HDR_W-1:0]  r_header,     n_header;
    logic [15:0]       r_offset,     n_offset;
    logic              r_closed,     n_closed;

    logic              r_out_valid;
    logic [1:0]        r_status,     n_status;
    logic [1:0]        r_kind,       n_kind;
    logic [IDX_W-1:0]  r_idx,        n_idx;
    logic [7:0]        r_val,        n_val;
    logic [HDR_W-1:0]  r_out_header;
    logic [15:0]       r_out_offset;

    logic              pop;
    logic [7:0]        b;
    logic [9:0]        hdr_len;
    logic [4:0]        id_inc;
    logic [DCNT_W-1:0] data_inc;

    assign pop       = i_tok_valid && (!r_out_valid || !i_stall);
    assign o_tok_pop = pop;
    assign b         = i_token.data;
    assign hdr_len   = r_header[9:0];
    assign id_inc    = r_id_count + 5'd1;
    assign data_inc  = r_data_count + 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_id_count   = r_id_count;
        n_data_count = r_data_count;
        n_crc        = r_crc;
        n_header     = r_header;
        n_offset     = r_offset;
        n_closed     = r_closed;
        n_status     = ST_IDLE;
        n_kind       = KIND_NONE;
        n_idx        = '0;
        n_val        = 8'h00;
        if (i_token.clear) begin
            n_phase      = PH_CODE;
            n_id_count   = '0;
            n_data_count = '0;
            n_crc        = CRC_INIT;
            n_header     = '0;
            n_offset     = '0;
            n_closed     = 1'b0;
        end else if (!r_closed && !i_token.dropped) begin
            if (r_phase > PH_CODE && r_phase < PH_CRC1) begin
                n_crc = crc16_byte(r_crc, b);
            end
            unique case (r_phase)
                PH_CODE: begin
                    n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    n_header[7:0] = b;
                    n_phase       = PH_HDR2;
                end
                PH_HDR2: begin
                    n_header[15:8] = b;
                    n_phase        = PH_HDR3;
                end
                PH_HDR3: begin
                    n_header[23:16] = b;
                    n_phase         = PH_ID;
                end
                PH_ID: begin
                    n_kind     = KIND_ID;
                    n_idx      = IDX_W'(r_id_count);
                    n_val      = b;
                    n_id_count = id_inc;
                    if (id_inc >= {1'b0, r_header[19:16]}) begin
                        if (r_header[15]) begin
                            if (i_offsets_enabled) begin
                                n_phase = PH_OFF1;
                            end else begin
                                n_status = ST_ERR;
                            end
                        end else if (hdr_len != 10'd0) begin
                            n_phase = PH_DATA;
                        end else begin
                            n_phase = PH_CRC1;
                        end
                    end
                end
                PH_OFF1: begin
                    n_offset = {8'h00, b};
                    n_phase  = PH_OFF2;
                end
                PH_OFF2: begin
                    n_offset = {b, r_offset[7:0]};
                    n_phase  = PH_DATA;
                end
                PH_DATA: begin
                    n_kind       = KIND_PAYLOAD;
                    n_idx        = IDX_W'(r_data_count);
                    n_val        = b;
                    n_data_count = data_inc;
                    if (32'(data_inc) >= 32'(hdr_len) || 32'(data_inc) >= 32'(PAYLOAD_MAX)) begin
                        n_phase = PH_CRC1;
                    end
                end
                PH_CRC1: begin
                    if (b == r_crc[7:0]) begin
                        n_phase = PH_CRC2;
                    end else begin
                        n_status = ST_ERR;
                    end
                end
                PH_CRC2: begin
                    n_status = (b == r_crc[15:8]) ? ST_OK : ST_ERR;
                end
                default: begin
                    n_status = ST_ERR;
                end
            endcase
            if (n_status != ST_IDLE) begin
                n_closed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CODE;
            r_id_count   <= '0;
            r_data_count <= '0;
            r_crc        <= CRC_INIT;
            r_header     <= '0;
            r_offset     <= '0;
            r_closed     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop) begin
                r_phase      <= n_phase;
                r_id_count   <= n_id_count;
                r_data_count <= n_data_count;
                r_crc        <= n_crc;
                r_header     <= n_header;
                r_offset     <= n_offset;
                r_closed     <= n_closed;
                r_out_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_status     <= n_status;
            r_kind       <= n_kind;
            r_idx        <= n_idx;
            r_val        <= n_val;
            r_out_header <= n_header;
            r_out_offset <= n_offset;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_status = r_status;
    assign o_byte_kind    = r_kind;
    assign o_byte_index   = r_idx;
    assign o_byte_value   = r_val;
    assign o_header       = r_out_header;
    assign o_offset       = r_out_offset;

endmodule

// ----- bench/tb_cobs_crc_packet_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_cobs_crc_packet_decoder
// Self-checking bench for the COBS packet decoder. Frames are built and
// COBS-stuffed here, sent byte by byte with random gaps and output stalls,
// and every result is compared field by field against a cycle-free decoder
// model that tracks the frame state and the offsets-enable register.
// ----------------------------------------------------------------------------
module tb_cobs_crc_packet_decoder;

    import ccpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [9:0]  index;
        logic [7:0]  value;
        logic [9:0]  payload_length;
        logic [3:0]  message_type;
        logic        internal_flag;
        logic        offset_flag;
        logic [3:0]  id_length;
        logic        response_flag;
        logic [2:0]  ack_number;
        logic [15:0] offset_value;
    } t_decode_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_frame_status;
    logic [1:0]  o_byte_kind;
    logic [9:0]  o_byte_index;
    logic [7:0]  o_byte_value;
    logic [9:0]  o_payload_length;
    logic [3:0]  o_message_type;
    logic        o_internal_flag;
    logic        o_offset_flag;
    logic [3:0]  o_id_length;
    logic        o_response_flag;
    logic [2:0]  o_ack_number;
    logic [15:0] o_offset_value;

    cobs_crc_packet_decoder u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_status   (o_frame_status),
        .o_byte_kind      (o_byte_kind),
        .o_byte_index     (o_byte_index),
        .o_byte_value     (o_byte_value),
        .o_payload_length (o_payload_length),
        .o_message_type   (o_message_type),
        .o_internal_flag  (o_internal_flag),
        .o_offset_flag    (o_offset_flag),
        .o_id_length      (o_id_length),
        .o_response_flag  (o_response_flag),
        .o_ack_number     (o_ack_number),
        .o_offset_value   (o_offset_value)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // decoder model state
    logic        offsets_en     = 1'b1;
    logic [3:0]  frm_phase      = PH_CODE;
    logic [4:0]  frm_id_count   = '0;
    logic [10:0] frm_data_count = '0;
    logic [7:0]  cobs_countdown = '0;
    logic [7:0]  cobs_last_code = '0;
    logic [15:0] frm_crc        = CRC_INIT;
    logic [23:0] frm_header     = '0;
    logic [15:0] frm_offset     = '0;
    logic        frm_closed     = 1'b0;

    t_decode_result decoded_results[$];
    logic [7:0]     link_bytes[$];
    int             mismatch_count = 0;
    int             idle_cycles = 0;
    int             sent_items = 0;
    logic           tx_burst = 1'b0;
    int             rx_hold = 0;

    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic t_decode_result decode_link_byte(input logic [7:0] rx);
        t_decode_result r;
        logic [7:0]     d;
        logic           dropped;
        r = '0;
        r.status = ST_IDLE;
        r.kind = KIND_NONE;
        d = rx;
        dropped = 1'b0;
        if (rx == 8'h00) begin
            frm_phase = PH_CODE;
            frm_id_count = '0;
            frm_data_count = '0;
            cobs_countdown = '0;
            cobs_last_code = '0;
            frm_crc = CRC_INIT;
            frm_header = '0;
            frm_offset = '0;
            frm_closed = 1'b0;
        end else if (!frm_closed) begin
            if (cobs_countdown > 8'd1) begin
                cobs_countdown = cobs_countdown - 8'd1;
            end else begin
                cobs_countdown = rx;
                dropped = (cobs_last_code == COBS_MAX_CODE);
                cobs_last_code = rx;
                d = 8'h00;
            end
            if (!dropped) begin
                if (frm_phase > PH_CODE && frm_phase < PH_CRC1) begin
                    frm_crc = crc_add_byte(frm_crc, d);
                end
                case (frm_phase)
                    PH_CODE: frm_phase = PH_HDR1;
                    PH_HDR1: begin
                        frm_header[7:0] = d;
                        frm_phase = PH_HDR2;
                    end
                    PH_HDR2: begin
                        frm_header[15:8] = d;
                        frm_phase = PH_HDR3;
                    end
                    PH_HDR3: begin
                        frm_header[23:16] = d;
                        frm_phase = PH_ID;
                    end
                    PH_ID: begin
                        r.kind = KIND_ID;
                        r.index = {5'd0, frm_id_count};
                        r.value = d;
                        frm_id_count = frm_id_count + 5'd1;
                        if (frm_id_count >= {1'b0, frm_header[19:16]}) begin
                            if (frm_header[15]) begin
                                if (offsets_en) begin
                                    frm_phase = PH_OFF1;
                                end else begin
                                    r.status = ST_ERR;
                                end
                            end else if (frm_header[9:0] != 10'd0) begin
                                frm_phase = PH_DATA;
                            end else begin
                                frm_phase = PH_CRC1;
                            end
                        end
                    end
                    PH_OFF1: begin
                        frm_offset = {8'h00, d};
                        frm_phase = PH_OFF2;
                    end
                    PH_OFF2: begin
                        frm_offset[15:8] = d;
                        frm_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        r.kind = KIND_PAYLOAD;
                        r.index = frm_data_count[9:0];
                        r.value = d;
                        frm_data_count = frm_data_count + 11'd1;
                        if (frm_data_count >= {1'b0, frm_header[9:0]}
                                || frm_data_count >= PAYLOAD_MAX) begin
                            frm_phase = PH_CRC1;
                        end
                    end
                    PH_CRC1: begin
                        if (d == frm_crc[7:0]) begin
                            frm_phase = PH_CRC2;
                        end else begin
                            r.status = ST_ERR;
                        end
                    end
                    PH_CRC2: r.status = (d == frm_crc[15:8]) ? ST_OK : ST_ERR;
                    default: r.status = ST_ERR;
                endcase
                if (r.status != ST_IDLE) begin
                    frm_closed = 1'b1;
                end
            end
        end
        r.payload_length = frm_header[9:0];
        r.message_type = frm_header[13:10];
        r.internal_flag = frm_header[14];
        r.offset_flag = frm_header[15];
        r.id_length = frm_header[19:16];
        r.response_flag = frm_header[20];
        r.ack_number = frm_header[23:21];
        r.offset_value = frm_offset;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // sample both channels, predict on accepted input, check on accepted output
    always @(posedge i_clk) begin : monitor
        t_decode_result seen;
        t_decode_result want;
        logic           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                offsets_en = i_cfg_wdata;
            end
            if (i_valid && !o_stall) begin
                decoded_results.push_back(decode_link_byte(i_rx_byte));
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                seen = {o_frame_status, o_byte_kind, o_byte_index, o_byte_value,
                        o_payload_length, o_message_type, o_internal_flag,
                        o_offset_flag, o_id_length, o_response_flag, o_ack_number,
                        o_offset_value};
                if (decoded_results.size() == 0) begin
                    report_mismatch("unexpected transaction", 16'(seen.status), 16'h0);
                end else begin
                    want = decoded_results.pop_front();
                    check_field("frame_status", 16'(seen.status), 16'(want.status));
                    check_field("byte_kind", 16'(seen.kind), 16'(want.kind));
                    check_field("byte_index", 16'(seen.index), 16'(want.index));
                    check_field("byte_value", 16'(seen.value), 16'(want.value));
                    check_field("payload_length", 16'(seen.payload_length),
                                16'(want.payload_length));
                    check_field("message_type", 16'(seen.message_type),
                                16'(want.message_type));
                    check_field("internal_flag", 16'(seen.internal_flag),
                                16'(want.internal_flag));
                    check_field("offset_flag", 16'(seen.offset_flag), 16'(want.offset_flag));
                    check_field("id_length", 16'(seen.id_length), 16'(want.id_length));
                    check_field("response_flag", 16'(seen.response_flag),
                                16'(want.response_flag));
                    check_field("ack_number", 16'(seen.ack_number), 16'(want.ack_number));
                    check_field("offset_value", seen.offset_value, want.offset_value);
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // output backpressure: short stalls, a few long ones, free-running stretches
    always @(negedge i_clk) begin : stall_gen
        int pick;
        if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                i_stall = 1'b0;
                rx_hold = $urandom_range(0, 8);
            end else if (pick < 85) begin
                i_stall = 1'b1;
                rx_hold = $urandom_range(0, 2);
            end else if (pick < 93) begin
                i_stall = 1'b1;
                rx_hold = $urandom_range(10, 40);
            end else begin
                i_stall = 1'b0;
                rx_hold = $urandom_range(50, 150);
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int pick;
        if (tx_burst) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_data(input logic nonzero);
        if (nonzero) begin
            return 8'($urandom_range(1, 255));
        end else if ($urandom_range(0, 7) == 0) begin
            return 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_link_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_rx_byte = b;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        sent_items++;
    endtask

    task automatic send_link_stream();
        foreach (link_bytes[i]) begin
            send_link_byte(link_bytes[i]);
        end
    endtask

    // build a frame body, append its CRC and COBS-stuff it behind a zero delimiter
    task automatic build_frame(input logic [9:0] len, input logic [3:0] mtype,
                               input logic internal_f, input logic offset_f,
                               input logic [3:0] idlen, input logic resp_f,
                               input logic [2:0] ack, input logic [15:0] offset_v,
                               input logic nonzero_data, input int crc_fault);
        logic [7:0]  body[$];
        logic [15:0] crc;
        int          n_id;
        int          n_pay;
        int          code_pos;
        int          code;
        body.push_back(len[7:0]);
        body.push_back({offset_f, internal_f, mtype, len[9:8]});
        body.push_back({ack, resp_f, idlen});
        n_id = (idlen == 4'd0) ? 1 : int'(idlen);
        repeat (n_id) body.push_back(rand_data(nonzero_data));
        if (offset_f) begin
            body.push_back(offset_v[7:0]);
            body.push_back(offset_v[15:8]);
        end
        n_pay = (len != 10'd0) ? int'(len) : (offset_f ? 1 : 0);
        repeat (n_pay) body.push_back(rand_data(nonzero_data));
        crc = CRC_INIT;
        foreach (body[i]) begin
            crc = crc_add_byte(crc, body[i]);
        end
        if (crc_fault == 1) begin
            crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
        end else if (crc_fault == 2) begin
            crc[15:8] = crc[15:8] ^ 8'($urandom_range(1, 255));
        end
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        link_bytes.delete();
        link_bytes.push_back(8'h00);
        code_pos = link_bytes.size();
        link_bytes.push_back(8'h00);
        code = 1;
        foreach (body[i]) begin
            if (body[i] == 8'h00) begin
                link_bytes[code_pos] = 8'(code);
                code_pos = link_bytes.size();
                link_bytes.push_back(8'h00);
                code = 1;
            end else begin
                link_bytes.push_back(body[i]);
                code++;
                if (code == 255) begin
                    link_bytes[code_pos] = COBS_MAX_CODE;
                    code_pos = link_bytes.size();
                    link_bytes.push_back(8'h00);
                    code = 1;
                end
            end
        end
        link_bytes[code_pos] = 8'(code);
    endtask

    task automatic send_random_frame(input int offset_pct);
        int   pick;
        int   fault;
        int   cut;
        logic big;
        logic [9:0] len;
        logic [3:0] idlen;
        pick = $urandom_range(0, 99);
        big = 1'b0;
        if (pick < 60) begin
            len = 10'($urandom_range(0, 6));
        end else if (pick < 92) begin
            len = 10'($urandom_range(7, 30));
        end else if (pick < 98) begin
            len = 10'($urandom_range(31, 100));
        end else begin
            len = 10'($urandom_range(101, 1023));
            big = 1'b1;
        end
        idlen = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3))
                                           : 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        fault = (pick < 10) ? 1 : (pick < 20) ? 2 : 0;
        build_frame(len, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 99) < offset_pct, idlen,
                    1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    16'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0, fault);
        if (big || $urandom_range(0, 99) < 8) begin
            cut = $urandom_range(2, (link_bytes.size() - 1 < 60) ? link_bytes.size() - 1 : 60);
            while (link_bytes.size() > cut) begin
                void'(link_bytes.pop_back());
            end
        end
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 4)) link_bytes.push_back(rand_data(1'b1));
        end
        if ($urandom_range(0, 99) < 6) begin
            link_bytes.delete();
            repeat ($urandom_range(1, 12)) link_bytes.push_back(rand_data(1'b0));
        end
        tx_burst = ($urandom_range(0, 4) == 0);
        send_link_stream();
    endtask

    task automatic write_offsets_enable(input logic en);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (decoded_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = en;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_directed_frames();
        tx_burst = 1'b0;
        build_frame(10'd0, 4'd0, 1'b0, 1'b0, 4'd0, 1'b0, 3'd0, 16'h0000, 1'b0, 0);
        send_link_stream();
        // all header flags high, offset of all ones, then bytes after close
        build_frame(10'd0, 4'hF, 1'b1, 1'b1, 4'd1, 1'b1, 3'd7, 16'hFFFF, 1'b1, 0);
        link_bytes.push_back(8'hFF);
        link_bytes.push_back(8'h01);
        send_link_stream();
        build_frame(10'd2, 4'd3, 1'b0, 1'b0, 4'd1, 1'b0, 3'd2, 16'h0000, 1'b0, 1);
        send_link_stream();
        build_frame(10'd1, 4'd5, 1'b1, 1'b0, 4'd0, 1'b1, 3'd4, 16'h0000, 1'b0, 2);
        send_link_stream();
    endtask

    task automatic test_random_frames();
        int stop_at;
        write_offsets_enable(1'b1);
        stop_at = sent_items + 300;
        while (sent_items < stop_at) begin
            send_random_frame(30);
        end
    endtask

    task automatic test_offsets_refused();
        int stop_at;
        write_offsets_enable(1'b0);
        stop_at = sent_items + 200;
        while (sent_items < stop_at) begin
            send_random_frame(50);
        end
        write_offsets_enable(1'b1);
    endtask

    task automatic test_long_cobs_groups();
        tx_burst = 1'b0;
        build_frame(10'd280, 4'd9, 1'b0, 1'b1, 4'd2, 1'b0, 3'd1, 16'h1234, 1'b1, 0);
        send_link_stream();
        build_frame(10'd260, 4'd2, 1'b1, 1'b0, 4'd0, 1'b1, 3'd6, 16'h0000, 1'b1, 2);
        send_link_stream();
    endtask

    task automatic test_link_noise();
        link_bytes.delete();
        repeat (60) link_bytes.push_back(rand_data(1'b0));
        tx_burst = 1'b1;
        send_link_stream();
    endtask

    initial begin : main
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_frames();
        test_random_frames();
        test_offsets_refused();
        test_long_cobs_groups();
        test_link_noise();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (decoded_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
